>>> hw/rtl/escd_pkg.sv
// shared types, constants and crc function for the esc telemetry frame decoder
`timescale 1ns / 1ps
`default_nettype none

package escd_pkg;

  // frame layout
  localparam int FRAME_BYTES = 10;
  localparam int DATA_BYTES  = FRAME_BYTES - 1;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  // crc-8, polynomial 0x07, msb first
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // one classified item handed from front to back
  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic             last;
  } escd_item_t;

  // fold one byte into the running crc
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/escd_front.sv
// front end: accepts bytes and tags each with its frame position
`timescale 1ns / 1ps
`default_nettype none

module escd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_start_i,
  output logic                push_o,
  output escd_pkg::escd_item_t item_o,
  input  logic                full_i
);
  import escd_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DATA_BYTES);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] pos_eff;
  logic             is_last;
  logic             accept;

  // take an item whenever the queue has room
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  // classify the item: frame start restarts counting at byte 0
  assign pos_eff = frame_start_i ? '0 : pos_q;
  assign is_last = (pos_eff >= LAST_POS);

  assign item_o.data = rx_byte_i;
  assign item_o.pos  = pos_eff;
  assign item_o.last = is_last;

  // next position in the frame
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = is_last ? '0 : pos_eff + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // position never runs past the check byte
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= LAST_POS)
    else $error("frame position out of range");

  // a check byte always wraps the position back to zero
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_last |=> pos_q == '0)
    else $error("position did not wrap after check byte");

endmodule

`default_nettype wire

>>> hw/rtl/escd_queue.sv
// short queue of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none

module escd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  escd_pkg::escd_item_t item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output escd_pkg::escd_item_t item_o
);
  import escd_pkg::*;

  escd_item_t             mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QUEUE_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QUEUE_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // fill count stays within the depth
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue overfilled");

endmodule

`default_nettype wire

>>> hw/rtl/escd_back.sv
// back end: crc accumulation, byte capture and result register
`timescale 1ns / 1ps
`default_nettype none

module escd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  escd_pkg::escd_item_t item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          temperature_o,
  output logic [15:0]         voltage_o,
  output logic [15:0]         current_o,
  output logic [15:0]         consumption_o,
  output logic [15:0]         rpm_o,
  output logic                crc_ok_o
);
  import escd_pkg::*;

  logic [7:0] cap_q [DATA_BYTES];
  logic [7:0] crc_q, crc_d;
  logic [7:0] crc_base;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;
  logic       take_data, take_last;

  logic [7:0]  temperature_q;
  logic [15:0] voltage_q, current_q, consumption_q, rpm_q;
  logic        crc_ok_q;

  // data bytes always drain; the check byte needs a free result slot
  assign slot_free = !out_valid_q || out_ready_i;
  assign take_data = valid_i && !item_i.last;
  assign take_last = valid_i && item_i.last && slot_free;
  assign pop_o     = take_data || take_last;

  // byte 0 starts a fresh crc
  assign crc_base = (item_i.pos == '0) ? 8'h00 : crc_q;

  always_comb begin
    crc_d = crc_q;
    if (take_data) begin
      crc_d = crc8_fold(crc_base, item_i.data);
    end else if (take_last) begin
      crc_d = 8'h00;
    end
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (take_last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // capture data bytes at their frame position
  always_ff @(posedge clk_i) begin
    if (take_data) begin
      cap_q[item_i.pos] <= item_i.data;
    end
  end

  // result payload, loaded on the check byte
  always_ff @(posedge clk_i) begin
    if (take_last) begin
      temperature_q <= cap_q[0];
      voltage_q     <= {cap_q[1], cap_q[2]};
      current_q     <= {cap_q[3], cap_q[4]};
      consumption_q <= {cap_q[5], cap_q[6]};
      rpm_q         <= {cap_q[7], cap_q[8]};
      crc_ok_q      <= (item_i.data == crc_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign temperature_o = temperature_q;
  assign voltage_o     = voltage_q;
  assign current_o     = current_q;
  assign consumption_o = consumption_q;
  assign rpm_o         = rpm_q;
  assign crc_ok_o      = crc_ok_q;

  // a consumed check byte always leaves a result pending
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_last |=> out_valid_q && crc_q == 8'h00)
    else $error("check byte consumed without a result");

endmodule

`default_nettype wire

>>> hw/rtl/esc_telemetry_frame_decoder.sv
// top level of the esc telemetry frame decoder
//
// Input channel: one telemetry byte per item on rx_byte_i, with frame_start_i
// marking byte 0 of a frame and dropping any partial frame. Without frame
// starts, bytes are grouped in tens by count from reset.
// Output channel: one item per complete ten-byte frame carrying temperature,
// voltage, current, consumption, rpm (big-endian 16-bit) and crc_ok, which
// says whether byte 9 equals the crc-8 (poly 0x07, init 0) of bytes 0 to 8.
// Throughput: one input item per cycle while in_ready_o is high; the front tags
// bytes with their position and a two-entry queue feeds the back, which folds
// one byte per cycle into the crc.
// Result path: an accepted check byte is written into the queue; once it is at
// the head of the queue and the result register is free, it loads the result
// register, which drives the output.
// Stall: data bytes keep draining while a result waits; a check byte waits
// in the queue until the result register is free, and once the queue holds
// two items in_ready_o drops.
// Reset: frame position, crc, queue and result valid clear; no result pends.
`timescale 1ns / 1ps
`default_nettype none

module esc_telemetry_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  temperature_o,
  output logic [15:0] voltage_o,
  output logic [15:0] current_o,
  output logic [15:0] consumption_o,
  output logic [15:0] rpm_o,
  output logic        crc_ok_o
);
  import escd_pkg::*;

  escd_item_t push_item, head_item;
  logic       push, full, head_valid, pop;

  // classify incoming bytes
  escd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .push_o        (push),
    .item_o        (push_item),
    .full_i        (full)
  );

  // decouple front and back
  escd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  // crc, capture and result
  escd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (head_valid),
    .item_i        (head_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .temperature_o (temperature_o),
    .voltage_o     (voltage_o),
    .current_o     (current_o),
    .consumption_o (consumption_o),
    .rpm_o         (rpm_o),
    .crc_ok_o      (crc_ok_o)
  );

endmodule

`default_nettype wire
